[hw/rtl/planar_sample_deinterleaver_defines.svh]
// Assertion macros shared by the planar sample deinterleaver RTL.
`ifndef PLANAR_SAMPLE_DEINTERLEAVER_DEFINES_SVH
`define PLANAR_SAMPLE_DEINTERLEAVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSD_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSD_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/psd_pkg.sv]
// Types, register indexes and sample size helpers of the planar sample deinterleaver.
package psd_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_COMPONENT_COUNT      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_COLUMNS         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_ROWS            = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LITTLE_ENDIAN_ORDER  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_ALIGNMENT        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_SIZE_CODES    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMPONENT_ALIGNMENTS = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_ORIGIN          = 3'd7;

  // Largest size code; the codes above it also mean sixteen bytes.
  localparam logic [2:0] SIZE_CODE_MAX = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_tile;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  component;
    logic [16:0] column;
    logic [16:0] row;
    logic [63:0] sample_low;
    logic [63:0] sample_high;
    logic        tile_done;
    logic        run_end;
  } out_item_t;

  // Data bytes of one sample for a size code.
  function automatic logic [4:0] data_bytes(input logic [2:0] code);
    logic [4:0] size;
    if (code >= SIZE_CODE_MAX) begin
      size = 5'd16;
    end else begin
      size = 5'd1 << code;
    end
    return size;
  endfunction

  // Sample slot length: the data bytes rounded up to a multiple of the alignment.
  // Below sixteen the alignment is small, so the multiple is picked from a short list.
  function automatic logic [7:0] slot_bytes(input logic [2:0] code, input logic [7:0] align);
    logic [4:0] size;
    logic [7:0] slot;
    logic [7:0] cand;
    size = data_bytes(code);
    slot = {3'd0, size};
    cand = 8'd0;
    if (align != 8'd0) begin
      if (align >= {3'd0, size}) begin
        slot = align;
      end else begin
        for (int m = 16; m >= 1; m--) begin
          cand = {4'd0, align[3:0]} * 8'(m);
          if (cand >= {3'd0, size}) begin
            slot = cand;
          end
        end
      end
    end
    return slot;
  endfunction

endpackage

[hw/rtl/planar_sample_deinterleaver.sv]
// Top level of the planar sample deinterleaver: byte stream in, aligned samples out.
//
//   Channel   Direction  Handshake               Payload
//   cfg       in         cfg_write               cfg_index, cfg_data (32 bits)
//   in        in         in_valid / in_stall     in_item  (one raw tile byte)
//   out       out        out_valid / out_stall   out_item (one sample or error)
//
// One byte is taken per cycle while in_stall is low; its results are registered into the
// output queue as it is taken. A byte yields at most two results; a two-entry output queue
// holds them, and the input is stalled when the queue could not take every result of the
// waiting byte. After reset and after every register write, the row padding of each plane
// is worked out by a bit-serial remainder unit, during which in_stall is high. Reset is
// synchronous and clears the walk counters, the assembly buffer and both queue entries.
`include "planar_sample_deinterleaver_defines.svh"

module planar_sample_deinterleaver
  import psd_pkg::*;
#(
  parameter int unsigned MAX_COMPONENTS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item
);

  // Plane index width, number of stored planes and a width that can hold the count.
  localparam int unsigned PW     = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int unsigned PLANES = 1 << PW;
  localparam int unsigned EW     = PW + 1;
  // Dividend width of the row length: an 8-bit slot times a 16-bit column count.
  localparam int unsigned LEN_W  = 24;
  localparam int unsigned STEP_W = $clog2(LEN_W + 1);

  localparam logic [1:0] PH_DATA   = 2'd0;
  localparam logic [1:0] PH_ROWPAD = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam logic [1:0] RC_IDLE  = 2'd0;
  localparam logic [1:0] RC_LOAD  = 2'd1;
  localparam logic [1:0] RC_DIV   = 2'd2;
  localparam logic [1:0] RC_STORE = 2'd3;

  // Configuration registers.
  logic [2:0]  component_count;
  logic [15:0] tile_columns;
  logic [15:0] tile_rows;
  logic        little_endian_order;
  logic [15:0] row_alignment;
  logic [11:0] sample_size_codes;
  logic [31:0] component_alignments;
  logic [31:0] tile_origin;

  always_ff @(posedge clk) begin
    if (rst) begin
      component_count      <= 3'd1;
      tile_columns         <= 16'd1;
      tile_rows            <= 16'd1;
      little_endian_order  <= 1'b0;
      row_alignment        <= 16'd0;
      sample_size_codes    <= 12'd0;
      component_alignments <= 32'd0;
      tile_origin          <= 32'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_COMPONENT_COUNT:      component_count      <= cfg_data[2:0];
        CFG_TILE_COLUMNS:         tile_columns         <= cfg_data[15:0];
        CFG_TILE_ROWS:            tile_rows            <= cfg_data[15:0];
        CFG_LITTLE_ENDIAN_ORDER:  little_endian_order  <= cfg_data[0];
        CFG_ROW_ALIGNMENT:        row_alignment        <= cfg_data[15:0];
        CFG_SAMPLE_SIZE_CODES:    sample_size_codes    <= cfg_data[11:0];
        CFG_COMPONENT_ALIGNMENTS: component_alignments <= cfg_data;
        CFG_TILE_ORIGIN:          tile_origin          <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective limits: a zero count of columns, rows or planes behaves as one, and the
  // plane count is capped at the number of planes the block is built for.
  logic [15:0]   cols_eff;
  logic [15:0]   rows_eff;
  logic [EW-1:0] count_eff;

  always_comb begin
    cols_eff = (tile_columns == 16'd0) ? 16'd1 : tile_columns;
    rows_eff = (tile_rows == 16'd0) ? 16'd1 : tile_rows;
    if (component_count == 3'd0) begin
      count_eff = EW'(1);
    end else if (32'(component_count) > MAX_COMPONENTS) begin
      count_eff = EW'(MAX_COMPONENTS);
    end else begin
      count_eff = EW'(component_count);
    end
  end

  // Size code and alignment of every plane; planes beyond the fourth have neither field
  // and use single-byte, unaligned samples.
  logic [2:0] plane_code  [PLANES];
  logic [7:0] plane_align [PLANES];

  for (genvar g = 0; g < PLANES; g++) begin : g_plane
    if (g < 4) begin : g_field
      assign plane_code[g]  = sample_size_codes[3*g +: 3];
      assign plane_align[g] = component_alignments[8*g +: 8];
    end else begin : g_none
      assign plane_code[g]  = 3'd0;
      assign plane_align[g] = 8'd0;
    end
  end

  // Row padding per plane. The row length is divided by the row alignment one bit per
  // cycle; the padding is what completes the last partial multiple.
  logic [1:0]        rc_state;
  logic [PW-1:0]     rc_plane;
  logic [STEP_W-1:0] rc_step;
  logic [LEN_W-1:0]  rc_dividend;
  logic [15:0]       rc_rem;
  logic [15:0]       rpad [PLANES];
  logic [16:0]       rem_shift;
  logic [16:0]       rem_sub;
  logic [15:0]       rem_next;
  logic [7:0]        rc_slot;
  logic              busy;

  always_comb begin
    rc_slot   = slot_bytes(plane_code[rc_plane], plane_align[rc_plane]);
    rem_shift = {rc_rem, rc_dividend[LEN_W-1]};
    rem_sub   = rem_shift - {1'b0, row_alignment};
    rem_next  = (rem_shift >= {1'b0, row_alignment}) ? rem_sub[15:0] : rem_shift[15:0];
    busy      = (rc_state != RC_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rc_state <= RC_LOAD;
      rc_plane <= '0;
    end else if (cfg_write) begin
      // Any register write may change a row length, so every plane is redone.
      rc_state <= RC_LOAD;
      rc_plane <= '0;
    end else begin
      unique case (rc_state)
        RC_IDLE: ;
        RC_LOAD: begin
          rc_dividend <= LEN_W'(rc_slot) * LEN_W'(cols_eff);
          rc_rem      <= 16'd0;
          rc_step     <= STEP_W'(LEN_W);
          rc_state    <= RC_DIV;
        end
        RC_DIV: begin
          rc_rem      <= rem_next;
          rc_dividend <= {rc_dividend[LEN_W-2:0], 1'b0};
          rc_step     <= rc_step - STEP_W'(1);
          if (rc_step == STEP_W'(1)) begin
            rc_state <= RC_STORE;
          end
        end
        RC_STORE: begin
          if (row_alignment <= 16'd1 || rc_rem == 16'd0) begin
            rpad[rc_plane] <= 16'd0;
          end else begin
            rpad[rc_plane] <= row_alignment - rc_rem;
          end
          if (rc_plane == PW'(PLANES - 1)) begin
            rc_state <= RC_IDLE;
          end else begin
            rc_plane <= rc_plane + PW'(1);
            rc_state <= RC_LOAD;
          end
        end
        default: rc_state <= RC_IDLE;
      endcase
    end
  end

  // Walk state.
  logic [1:0]    phase;
  logic [PW-1:0] plane_index;
  logic [15:0]   column_count;
  logic [15:0]   row_count;
  logic [4:0]    byte_in_sample;
  logic [7:0]    sample_align_phase;
  logic [15:0]   row_align_phase;
  logic [63:0]   assembly_low;
  logic [63:0]   assembly_high;

  logic [1:0]    phase_next;
  logic [PW-1:0] plane_index_next;
  logic [15:0]   column_count_next;
  logic [15:0]   row_count_next;
  logic [4:0]    byte_in_sample_next;
  logic [7:0]    sample_align_phase_next;
  logic [15:0]   row_align_phase_next;
  logic [63:0]   assembly_low_next;
  logic [63:0]   assembly_high_next;

  // The state this byte starts from: a first byte of a tile starts from cleared counters.
  logic [1:0]    cur_phase;
  logic [PW-1:0] cur_plane;
  logic [15:0]   cur_col;
  logic [15:0]   cur_row;
  logic [4:0]    cur_bis;
  logic [7:0]    cur_sap;
  logic [15:0]   cur_rap;
  logic [63:0]   cur_low;
  logic [63:0]   cur_high;

  logic [4:0]    size;
  logic [7:0]    slot;
  logic [7:0]    pad;
  logic [15:0]   rpad_sel;
  logic          last_col;
  logic          last_row;
  logic          last_plane;
  logic [63:0]   byte_word;
  logic [63:0]   half_in;
  logic [63:0]   half_out;
  logic [63:0]   asm_low;
  logic [63:0]   asm_high;
  logic          emit;
  logic          err;
  logic          do_next_row;
  out_item_t     sample_item;
  out_item_t     err_item;
  out_item_t     res0;
  out_item_t     res1;
  logic [1:0]    res_count;

  always_comb begin
    if (in_item.first_of_tile) begin
      cur_phase = PH_DATA;
      cur_plane = '0;
      cur_col   = 16'd0;
      cur_row   = 16'd0;
      cur_bis   = 5'd0;
      cur_sap   = 8'd0;
      cur_rap   = 16'd0;
      cur_low   = 64'd0;
      cur_high  = 64'd0;
    end else begin
      cur_phase = phase;
      cur_plane = plane_index;
      cur_col   = column_count;
      cur_row   = row_count;
      cur_bis   = byte_in_sample;
      cur_sap   = sample_align_phase;
      cur_rap   = row_align_phase;
      cur_low   = assembly_low;
      cur_high  = assembly_high;
    end

    size     = data_bytes(plane_code[cur_plane]);
    slot     = slot_bytes(plane_code[cur_plane], plane_align[cur_plane]);
    pad      = slot - {3'd0, size};
    rpad_sel = rpad[cur_plane];

    last_col   = ({1'b0, cur_col} + 17'd1) >= {1'b0, cols_eff};
    last_row   = ({1'b0, cur_row} + 17'd1) >= {1'b0, rows_eff};
    last_plane = ({1'b0, cur_plane} + EW'(1)) >= count_eff;

    // Byte assembly: bytes 0 to 7 of a sample go to the low half, 8 to 15 to the high.
    byte_word = {56'd0, in_item.data_byte};
    half_in   = cur_bis[3] ? cur_high : cur_low;
    if (little_endian_order) begin
      half_out = half_in | (byte_word << {cur_bis[2:0], 3'b000});
    end else begin
      half_out = {half_in[55:0], in_item.data_byte};
    end
    asm_low  = cur_low;
    asm_high = cur_high;

    phase_next              = cur_phase;
    plane_index_next        = cur_plane;
    column_count_next       = cur_col;
    row_count_next          = cur_row;
    byte_in_sample_next     = cur_bis;
    sample_align_phase_next = cur_sap;
    row_align_phase_next    = cur_rap;
    emit                    = 1'b0;
    do_next_row             = 1'b0;

    case (cur_phase)
      PH_DATA: begin
        if (cur_bis < size) begin
          if (cur_bis[3]) begin
            asm_high = half_out;
          end else begin
            asm_low = half_out;
          end
          byte_in_sample_next = cur_bis + 5'd1;
        end else begin
          sample_align_phase_next = cur_sap + 8'd1;
        end
        if (byte_in_sample_next >= size && sample_align_phase_next >= pad) begin
          emit                    = 1'b1;
          byte_in_sample_next     = 5'd0;
          sample_align_phase_next = 8'd0;
          if (last_col) begin
            column_count_next = 16'd0;
            if (last_row && last_plane) begin
              phase_next = PH_DONE;
            end else if (rpad_sel != 16'd0) begin
              row_align_phase_next = 16'd0;
              phase_next           = PH_ROWPAD;
            end else begin
              do_next_row = 1'b1;
            end
          end else begin
            column_count_next = cur_col + 16'd1;
          end
        end
      end
      PH_ROWPAD: begin
        row_align_phase_next = cur_rap + 16'd1;
        if (row_align_phase_next >= rpad_sel) begin
          phase_next  = PH_DATA;
          do_next_row = 1'b1;
        end
      end
      default: ;
    endcase

    if (do_next_row) begin
      row_align_phase_next = 16'd0;
      if (last_row) begin
        row_count_next   = 16'd0;
        plane_index_next = cur_plane + PW'(1);
        if (last_plane) begin
          phase_next = PH_DONE;
        end
      end else begin
        row_count_next = cur_row + 16'd1;
      end
    end

    // A delivered sample empties the assembly buffer.
    assembly_low_next  = emit ? 64'd0 : asm_low;
    assembly_high_next = emit ? 64'd0 : asm_high;

    // The data running out before the tile is complete closes the tile with an error.
    err = in_item.end_of_data && (phase_next != PH_DONE);
    if (err) begin
      phase_next = PH_DONE;
    end

    sample_item.status      = 1'b0;
    sample_item.component   = 2'(cur_plane);
    sample_item.column      = {1'b0, tile_origin[15:0]} + {1'b0, cur_col};
    sample_item.row         = {1'b0, tile_origin[31:16]} + {1'b0, cur_row};
    sample_item.sample_low  = asm_low;
    sample_item.sample_high = (size == 5'd16) ? asm_high : 64'd0;
    sample_item.tile_done   = last_col && last_row && last_plane;
    sample_item.run_end     = !err;

    err_item         = '0;
    err_item.status  = 1'b1;
    err_item.run_end = 1'b1;

    res0      = emit ? sample_item : err_item;
    res1      = err_item;
    res_count = {1'b0, emit} + {1'b0, err};
  end

  // Two-entry output queue: head register drives the port, the second entry sits behind.
  logic      a_valid;
  logic      b_valid;
  out_item_t a_item;
  out_item_t b_item;
  logic      a_valid_next;
  logic      b_valid_next;
  out_item_t a_item_next;
  out_item_t b_item_next;
  logic      drain;
  logic      accept;
  logic [1:0] occ_after;

  always_comb begin
    drain = a_valid && !out_stall;
    if (drain) begin
      a_valid_next = b_valid;
      a_item_next  = b_item;
      b_valid_next = 1'b0;
    end else begin
      a_valid_next = a_valid;
      a_item_next  = a_item;
      b_valid_next = b_valid;
    end
    b_item_next = b_item;
    occ_after   = {1'b0, a_valid_next} + {1'b0, b_valid_next};

    in_stall = busy || ((3'(occ_after) + 3'(res_count)) > 3'd2);
    accept   = in_valid && !in_stall;

    if (accept) begin
      if (res_count == 2'd2) begin
        a_valid_next = 1'b1;
        a_item_next  = res0;
        b_valid_next = 1'b1;
        b_item_next  = res1;
      end else if (res_count == 2'd1) begin
        if (a_valid_next) begin
          b_valid_next = 1'b1;
          b_item_next  = res0;
        end else begin
          a_valid_next = 1'b1;
          a_item_next  = res0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= a_valid_next;
      b_valid <= b_valid_next;
    end
    a_item <= a_item_next;
    b_item <= b_item_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_DATA;
      plane_index        <= '0;
      column_count       <= 16'd0;
      row_count          <= 16'd0;
      byte_in_sample     <= 5'd0;
      sample_align_phase <= 8'd0;
      row_align_phase    <= 16'd0;
      assembly_low       <= 64'd0;
      assembly_high      <= 64'd0;
    end else if (accept) begin
      phase              <= phase_next;
      plane_index        <= plane_index_next;
      column_count       <= column_count_next;
      row_count          <= row_count_next;
      byte_in_sample     <= byte_in_sample_next;
      sample_align_phase <= sample_align_phase_next;
      row_align_phase    <= row_align_phase_next;
      assembly_low       <= assembly_low_next;
      assembly_high      <= assembly_high_next;
    end
  end

  assign out_valid = a_valid;
  assign out_item  = a_item;

  `PSD_ASSERT_IMPL(a_queue_order, clk, rst, b_valid, a_valid, "second queue entry filled while the head is empty")
  `PSD_ASSERT_IMPL(a_stall_busy, clk, rst, busy, in_stall, "byte taken while row padding is being recomputed")
  `PSD_ASSERT_IMPL(a_error_ends_run, clk, rst, out_valid && out_item.status, out_item.run_end, "error result not marked as the last of its byte")
  `PSD_ASSERT_NEXT(a_end_closes, clk, rst, in_valid && !in_stall && in_item.end_of_data, phase == PH_DONE, "tile still open after its final byte")

endmodule
